// ----- rtl/priority_eviction_record_table_unit_defines.svh -----
// Assertion macros used by the record table unit.
`ifndef PRIORITY_EVICTION_RECORD_TABLE_UNIT_DEFINES_SVH
`define PRIORITY_EVICTION_RECORD_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge out of reset.
`define PERT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// A condition that must be followed by another in the next cycle.
`define PERT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define PERT_ASSERT(lbl, prop, msg)
`define PERT_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ----- rtl/pert_pkg.sv -----
package pert_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_TOUCH  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NOT_FOUND    = 2'd1,
    ST_ID_EXHAUSTED = 2'd2,
    ST_SEQ_EXHAUSTED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FINISH
  } fsm_e;

  localparam logic [6:0] CAP_RESET = 7'd64;

endpackage

// ----- rtl/pert_ram.sv -----
module pert_ram #(
  parameter int WIDTH = 144,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic                                   we_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Single port, registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- rtl/priority_eviction_record_table_unit.sv -----
// Record table with priority eviction. Each command word is accepted only
// while the block is idle and produces exactly one result word. The record
// fields live in one single-port RAM with a registered read; valid bits and
// the occupancy count are flip-flops. An erase, a touch and an insert into a
// full table sweep every RAM entry once before the final step; an insert
// with free room, an insert error found before the sweep, or the unused
// command goes from accept straight to the final step. The next word is
// taken only after the final step, once the block is idle again.
// A result that waits at the output does not block acceptance of the next
// word; the block only stalls its final step until the output is free.
`include "priority_eviction_record_table_unit_defines.svh"
module priority_eviction_record_table_unit #(
  parameter int CAPACITY     = 64,
  parameter int COUNTER_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [6:0]  cfg_wr_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] lookup_id_i,
  input  logic [15:0] confidence_i,
  input  logic [31:0] timestamp_i,
  input  logic        new_access_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] result_id_o,
  output logic        evicted_o,
  output logic [31:0] evicted_id_o,
  output logic [6:0]  occupancy_o
);
  import pert_pkg::*;

  localparam int CB    = COUNTER_BITS;
  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW    = $clog2(CAPACITY + 1);
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  // Field order gives the eviction priority as one unsigned compare.
  typedef struct packed {
    logic [15:0]   conf;
    logic [CB-1:0] hits;
    logic [CB-1:0] last_acc;
    logic [CB-1:0] tstamp;
    logic [CB-1:0] id;
  } entry_t;

  fsm_e state_q, state_d;

  logic [6:0]          cap_q;
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [OW-1:0]       occ_q, occ_d;
  logic [CB-1:0]       next_id_q, next_id_d;
  logic [CB-1:0]       seq_q, seq_d;

  // Captured command word.
  logic [1:0]  cmd_q;
  logic [31:0] rid_q;
  logic [15:0] conf_q;
  logic [CB-1:0] ts_q;
  logic        nacc_q;
  logic        need_evict_q;

  // Sweep state.
  logic [AW:0]   issue_q, issue_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_idx_q, pend_idx_d;
  logic          have_q, have_d;
  logic [AW-1:0] best_idx_q, best_idx_d;
  entry_t        best_q, best_d;

  // Output register.
  logic          out_valid_q, out_valid_d;
  logic [1:0]    status_q, status_d;
  logic [31:0]   res_id_q, res_id_d;
  logic          ev_q, ev_d;
  logic [31:0]   ev_id_q, ev_id_d;
  logic [6:0]    occ_out_q, occ_out_d;

  // RAM port.
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  entry_t        ram_wdata, ram_rdata;

  logic          accept, scan_done, out_free, fin;
  logic [31:0]   cap_eff;
  logic [CB-1:0] ts_in;
  logic          in_full, in_id_exh, in_seq_exh;

  pert_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign accept    = in_valid_i && (state_q == FSM_IDLE);
  assign in_stall_o = (state_q != FSM_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign fin       = (state_q == FSM_FINISH) && out_free;
  assign scan_done = (issue_q == (AW+1)'(CAPACITY)) && !pend_q;

  // Effective capacity and accept-time checks.
  always_comb begin
    if (cap_q == 7'd0) begin
      cap_eff = 32'd1;
    end else if (32'(cap_q) > 32'(CAPACITY)) begin
      cap_eff = 32'(CAPACITY);
    end else begin
      cap_eff = 32'(cap_q);
    end
    if (64'(timestamp_i) > 64'(CMAX)) begin
      ts_in = CMAX;
    end else begin
      ts_in = CB'(timestamp_i);
    end
    in_full    = (32'(occ_q) >= cap_eff);
    in_id_exh  = (next_id_q == '0);
    in_seq_exh = (ts_in == '0) && (seq_q == CMAX);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          if (command_i == CMD_ERASE || command_i == CMD_TOUCH) begin
            state_d = FSM_SCAN;
          end else if (command_i == CMD_INSERT && !in_id_exh && !in_seq_exh && in_full) begin
            state_d = FSM_SCAN;
          end else begin
            state_d = FSM_FINISH;
          end
        end
      end
      FSM_SCAN: begin
        if (scan_done) begin
          state_d = FSM_FINISH;
        end
      end
      FSM_FINISH: begin
        if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Sweep, read-modify-write and result datapath.
  always_comb begin
    logic [CAPACITY-1:0] vclr;
    logic [AW-1:0]       free_idx;
    logic                free_found;
    logic                evict;
    logic [CB-1:0]       ts_use;
    entry_t              rd;
    issue_d     = issue_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    have_d      = have_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    valid_d     = valid_q;
    occ_d       = occ_q;
    next_id_d   = next_id_q;
    seq_d       = seq_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    res_id_d    = res_id_q;
    ev_d        = ev_q;
    ev_id_d     = ev_id_q;
    occ_out_d   = occ_out_q;
    ram_addr    = issue_q[AW-1:0];
    ram_we      = 1'b0;
    ram_wdata   = best_q;
    rd          = ram_rdata;
    vclr        = valid_q;
    free_idx    = '0;
    free_found  = 1'b0;
    evict       = 1'b0;
    ts_use      = ts_q;

    if (accept) begin
      issue_d = '0;
      have_d  = 1'b0;
    end

    // Issue one read a cycle and judge the entry that returns.
    if (state_q == FSM_SCAN) begin
      if (issue_q != (AW+1)'(CAPACITY)) begin
        pend_d     = 1'b1;
        pend_idx_d = issue_q[AW-1:0];
        issue_d    = issue_q + 1'b1;
      end
      if (pend_q && valid_q[pend_idx_q]) begin
        if (cmd_q == CMD_INSERT) begin
          if (!have_q || (rd < best_q)) begin
            have_d     = 1'b1;
            best_d     = rd;
            best_idx_d = pend_idx_q;
          end
        end else if (!have_q && (64'(rd.id) == 64'(rid_q))) begin
          have_d     = 1'b1;
          best_d     = rd;
          best_idx_d = pend_idx_q;
        end
      end
    end

    // Final step: update state, write back and load the result word.
    if (fin) begin
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      res_id_d    = rid_q;
      ev_d        = 1'b0;
      ev_id_d     = '0;
      case (cmd_q)
        CMD_INSERT: begin
          res_id_d = '0;
          if (next_id_q == '0) begin
            status_d = ST_ID_EXHAUSTED;
          end else if (ts_q == '0 && seq_q == CMAX) begin
            status_d = ST_SEQ_EXHAUSTED;
          end else begin
            evict = need_evict_q && have_q;
            if (evict) begin
              vclr[best_idx_q] = 1'b0;
              ev_d    = 1'b1;
              ev_id_d = 32'(best_q.id);
            end
            if (ts_q == '0) begin
              seq_d  = seq_q + 1'b1;
              ts_use = seq_q + 1'b1;
            end else if (ts_q > seq_q) begin
              seq_d = ts_q;
            end
            for (int i = CAPACITY - 1; i >= 0; i--) begin
              if (!vclr[i]) begin
                free_idx   = AW'(i);
                free_found = 1'b1;
              end
            end
            valid_d = vclr;
            if (free_found) begin
              valid_d[free_idx] = 1'b1;
              ram_addr          = free_idx;
              ram_we            = 1'b1;
              ram_wdata.conf     = conf_q;
              ram_wdata.hits     = '0;
              ram_wdata.last_acc = '0;
              ram_wdata.tstamp   = ts_use;
              ram_wdata.id       = next_id_q;
              if (!evict) begin
                occ_d = occ_q + 1'b1;
              end
            end
            res_id_d  = 32'(next_id_q);
            next_id_d = (next_id_q == CMAX) ? '0 : next_id_q + 1'b1;
          end
        end
        CMD_ERASE: begin
          if (!have_q) begin
            status_d = ST_NOT_FOUND;
          end else begin
            valid_d[best_idx_q] = 1'b0;
            occ_d = occ_q - 1'b1;
          end
        end
        CMD_TOUCH: begin
          if (!have_q) begin
            status_d = ST_NOT_FOUND;
          end else if (nacc_q && seq_q == CMAX) begin
            status_d = ST_SEQ_EXHAUSTED;
          end else begin
            seq_d    = seq_q + CB'(nacc_q);
            ram_addr = best_idx_q;
            ram_we   = 1'b1;
            ram_wdata.hits     = (best_q.hits == CMAX) ? best_q.hits : best_q.hits + 1'b1;
            ram_wdata.last_acc = seq_q + CB'(nacc_q);
          end
        end
        default: begin
        end
      endcase
      occ_out_d = 7'(occ_d);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cap_q       <= CAP_RESET;
      valid_q     <= '0;
      occ_q       <= '0;
      next_id_q   <= CB'(1);
      seq_q       <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_wr_en_i) begin
        cap_q <= cfg_wr_data_i;
      end
      valid_q     <= valid_d;
      occ_q       <= occ_d;
      next_id_q   <= next_id_d;
      seq_q       <= seq_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q        <= command_i;
      rid_q        <= lookup_id_i;
      conf_q       <= confidence_i;
      ts_q         <= ts_in;
      nacc_q       <= new_access_i;
      need_evict_q <= in_full;
    end
    pend_idx_q <= pend_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    status_q   <= status_d;
    res_id_q   <= res_id_d;
    ev_q       <= ev_d;
    ev_id_q    <= ev_id_d;
    occ_out_q  <= occ_out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign result_id_o  = res_id_q;
  assign evicted_o    = ev_q;
  assign evicted_id_o = ev_id_q;
  assign occupancy_o  = occ_out_q;

  `PERT_ASSERT(a_occ_matches_valid, $countones(valid_q) == 32'(occ_q), "occupancy drifted")
  `PERT_ASSERT(a_evict_ok, !out_valid_q || !ev_q || status_q == ST_OK, "eviction with error")
  `PERT_ASSERT_NEXT(a_busy_after_accept, accept, state_q != FSM_IDLE, "accept left block idle")

endmodule

// ----- test/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pert_pkg::*;

  localparam int unsigned ENTRIES = 64;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] lookup_id;
    logic [15:0] confidence;
    logic [31:0] timestamp;
    logic        new_access;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_id;
    logic        evicted;
    logic [31:0] evicted_id;
    logic [6:0]  occupancy;
  } result_word_t;

  // Table predictor with a queue of the results it expects.
  class record_table_scoreboard;
    bit          live[ENTRIES];
    logic [31:0] rec_id[ENTRIES];
    logic [15:0] rec_conf[ENTRIES];
    logic [31:0] rec_time[ENTRIES];
    logic [31:0] rec_hits[ENTRIES];
    logic [31:0] rec_last[ENTRIES];
    logic [31:0] next_id;
    logic [31:0] seq_count;
    logic [6:0]  capacity;
    result_word_t pending[$];
    int unsigned mismatches;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      next_id = 32'd1;
      seq_count = '0;
      capacity = CAP_RESET;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [6:0] value);
      capacity = value;
    endfunction

    function int find_slot(logic [31:0] id);
      foreach (live[i]) if (live[i] && rec_id[i] == id) return i;
      return -1;
    endfunction

    function logic [6:0] occupied();
      logic [6:0] n;
      n = '0;
      foreach (live[i]) if (live[i]) n++;
      return n;
    endfunction

    // True when slot a goes before slot b on eviction.
    function bit evicts_first(int a, int b);
      if (rec_conf[a] != rec_conf[b]) return rec_conf[a] < rec_conf[b];
      if (rec_hits[a] != rec_hits[b]) return rec_hits[a] < rec_hits[b];
      if (rec_last[a] != rec_last[b]) return rec_last[a] < rec_last[b];
      if (rec_time[a] != rec_time[b]) return rec_time[a] < rec_time[b];
      return rec_id[a] < rec_id[b];
    endfunction

    // A live id most of the time, otherwise an arbitrary one.
    function logic [31:0] pick_id();
      int slots[$];
      foreach (live[i]) if (live[i]) slots = {slots, i};
      if (slots.size() == 0 || $urandom_range(0, 4) == 0) return $urandom();
      return rec_id[slots[$urandom_range(0, slots.size() - 1)]];
    endfunction

    function void note_command(cmd_word_t w);
      result_word_t r;
      int k;
      int victim;
      int slot;
      logic [31:0] ts;
      logic [6:0] limit;
      r = '0;
      r.status = ST_OK;
      r.result_id = w.lookup_id;
      ts = w.timestamp;
      limit = (capacity == 0) ? 7'd1 : (capacity > ENTRIES) ? 7'(ENTRIES) : capacity;
      case (w.command)
        CMD_INSERT: begin
          r.result_id = '0;
          if (next_id == 0) begin
            r.status = ST_ID_EXHAUSTED;
          end else if (ts == 0 && seq_count == COUNT_MAX) begin
            r.status = ST_SEQ_EXHAUSTED;
          end else begin
            if (occupied() >= limit) begin
              victim = -1;
              foreach (live[i])
                if (live[i] && (victim < 0 || evicts_first(i, victim))) victim = i;
              if (victim >= 0) begin
                live[victim] = 1'b0;
                r.evicted = 1'b1;
                r.evicted_id = rec_id[victim];
              end
            end
            if (ts == 0) begin
              seq_count++;
              ts = seq_count;
            end else if (ts > seq_count) begin
              seq_count = ts;
            end
            slot = -1;
            foreach (live[i]) if (slot < 0 && !live[i]) slot = i;
            if (slot >= 0) begin
              live[slot] = 1'b1;
              rec_id[slot] = next_id;
              rec_conf[slot] = w.confidence;
              rec_time[slot] = ts;
              rec_hits[slot] = '0;
              rec_last[slot] = '0;
            end
            r.result_id = next_id;
            next_id = (next_id == COUNT_MAX) ? 32'd0 : next_id + 1;
          end
        end
        CMD_ERASE: begin
          k = find_slot(w.lookup_id);
          if (k < 0) r.status = ST_NOT_FOUND;
          else live[k] = 1'b0;
        end
        CMD_TOUCH: begin
          k = find_slot(w.lookup_id);
          if (k < 0) begin
            r.status = ST_NOT_FOUND;
          end else if (w.new_access && seq_count == COUNT_MAX) begin
            r.status = ST_SEQ_EXHAUSTED;
          end else begin
            if (w.new_access) seq_count++;
            if (rec_hits[k] != COUNT_MAX) rec_hits[k]++;
            rec_last[k] = seq_count;
          end
        end
        default: ;
      endcase
      r.occupancy = occupied();
      pending = {pending, r};
    endfunction

    function void check_result(result_word_t got);
      result_word_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.result_id !== want.result_id ||
          got.evicted !== want.evicted || got.evicted_id !== want.evicted_id ||
          got.occupancy !== want.occupancy) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_wr_en_i;
  logic [6:0]  cfg_wr_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  command_i;
  logic [31:0] lookup_id_i;
  logic [15:0] confidence_i;
  logic [31:0] timestamp_i;
  logic        new_access_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [31:0] result_id_o;
  logic        evicted_o;
  logic [31:0] evicted_id_o;
  logic [6:0]  occupancy_o;

  record_table_scoreboard table_sb;
  bit          idling_on;
  bit          word_taken;
  int unsigned cycle_count;

  priority_eviction_record_table_unit uut (
    .clk_i, .rst_ni, .cfg_wr_en_i, .cfg_wr_data_i,
    .in_valid_i, .in_stall_o, .command_i, .lookup_id_i, .confidence_i,
    .timestamp_i, .new_access_i,
    .out_valid_o, .out_stall_i, .status_o, .result_id_o, .evicted_o,
    .evicted_id_o, .occupancy_o
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Handshakes are sampled mid-cycle, where every signal is settled.
  always @(negedge clk_i) begin
    word_taken <= 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      table_sb.note_command({command_i, lookup_id_i, confidence_i, timestamp_i,
                             new_access_i});
      word_taken <= 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i)
      table_sb.check_result({status_o, result_id_o, evicted_o, evicted_id_o,
                             occupancy_o});
  end

  // Run time limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Output stalls come in short random bursts.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (idling_on && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Present one word and hold it until it is accepted.
  task automatic send_word(cmd_word_t w);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {command_i, lookup_id_i, confidence_i, timestamp_i, new_access_i} <= w;
    do @(posedge clk_i); while (!word_taken);
  endtask

  task automatic send_insert(logic [15:0] conf, logic [31:0] ts);
    send_word({CMD_INSERT, 32'($urandom()), conf, ts, 1'($urandom())});
  endtask

  task automatic send_lookup(logic [1:0] cmd, logic [31:0] id, logic acc);
    send_word({cmd, id, 16'($urandom()), 32'($urandom()), acc});
  endtask

  // Wait for the table to drain, then write the capacity register.
  task automatic write_capacity(logic [6:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (table_sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    table_sb.set_capacity(value);
  endtask

  // One random command, mostly inserts and lookups of live ids.
  task automatic send_random();
    int unsigned pick;
    logic [31:0] ts;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      case ($urandom_range(0, 3))
        0: ts = '0;
        1: ts = $urandom_range(1, 32'h7FFF_FFFF) & 32'h0FFF_FFFF;
        default: ts = table_sb.seq_count + $urandom_range(0, 500);
      endcase
      send_insert($urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 3)) : 16'($urandom()),
                  ts);
    end else if (pick < 7) begin
      send_lookup(CMD_ERASE, table_sb.pick_id(), 1'($urandom()));
    end else if (pick < 9) begin
      send_lookup(CMD_TOUCH, table_sb.pick_id(), 1'($urandom()));
    end else begin
      send_lookup(CMD_UNUSED, $urandom(), 1'($urandom()));
    end
  endtask

  initial begin
    logic [6:0] caps[6];
    table_sb = new();
    idling_on = 1'b1;
    cycle_count = 0;
    rst_ni = 1'b0;
    cfg_wr_en_i = 1'b0;
    cfg_wr_data_i = '0;
    in_valid_i = 1'b0;
    command_i = '0;
    lookup_id_i = '0;
    confidence_i = '0;
    timestamp_i = '0;
    new_access_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: field extremes, each command, error paths.
    send_insert(16'h0000, 32'd0);
    send_insert(16'hFFFF, 32'd0);
    send_insert(16'h8000, 32'd100);
    send_insert(16'h0001, 32'd50);
    send_insert(16'h0000, 32'd0);
    send_lookup(CMD_TOUCH, 32'd1, 1'b1);
    send_lookup(CMD_TOUCH, 32'd2, 1'b0);
    send_lookup(CMD_TOUCH, 32'd1, 1'b0);
    send_lookup(CMD_TOUCH, 32'hFFFF_FFFF, 1'b1);
    send_lookup(CMD_ERASE, 32'hFFFF_FFFF, 1'b0);
    send_lookup(CMD_ERASE, 32'd0, 1'b1);
    send_lookup(CMD_ERASE, 32'd3, 1'b0);
    send_lookup(CMD_ERASE, 32'd3, 1'b0);
    send_lookup(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1);
    send_lookup(CMD_UNUSED, 32'd0, 1'b0);
    send_insert(16'h7FFF, 32'h0000_FFFF);
    send_insert(16'h1234, 32'd0);

    // Random phases through a range of capacity settings.
    caps = '{7'd64, 7'd3, 7'd1, 7'd0, 7'd127, 7'd40};
    foreach (caps[p]) begin
      if (p != 0) write_capacity(caps[p]);
      repeat (90) send_random();
    end
    // Lower the limit below the current fill.
    write_capacity(7'd2);
    repeat (40) send_random();
    write_capacity(7'd64);

    // Final part without idling: run the sequence counter to its limit.
    idling_on = 1'b0;
    repeat (10) send_random();
    send_insert(16'hFFFF, 32'hFFFF_FFFF);
    send_insert(16'h0000, 32'd0);
    send_lookup(CMD_TOUCH, table_sb.pick_id(), 1'b1);
    send_lookup(CMD_TOUCH, table_sb.pick_id(), 1'b0);
    repeat (25) send_random();
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (table_sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (table_sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
